// File: sv/irpwc_pkg.sv
// shared types and constants for the ir pulse width capture unit
`timescale 1ns / 1ps
`default_nettype none

package irpwc_pkg;

    // default depth of the raw duration buffer
    localparam int BUFFER_DEPTH_DEF = 128;

    // receiver phase codes as reported in rx_state
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MARK  = 2'd1;
    localparam logic [1:0] PH_SPACE = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // configuration register indexes
    localparam logic CFG_GAP_THRESHOLD = 1'b0;
    localparam logic CFG_MARK_LEVEL    = 1'b1;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int TICK_W      = 16;
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 56;

    // per-tick status from the capture state machine, rx_state in the low bits
    typedef struct packed {
        logic              overflowed;
        logic [7:0]        length;
        logic [TICK_W-1:0] stored_ticks;
        logic [6:0]        stored_index;
        logic              stored_valid;
        logic [1:0]        rx_state;
    } t_status;

    // full result item as packed on the master tdata
    typedef struct packed {
        logic [TICK_W-1:0] read_ticks;
        t_status           status;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

// File: sv/irpwc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module irpwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/irpwc_core.sv
// capture state machine: tick timer, phase, fill count and overflow flag
`timescale 1ns / 1ps
`default_nettype none

module irpwc_core
    import irpwc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_adv,
    input  wire logic                            i_is_mark,
    input  wire logic                            i_rearm,
    input  wire logic [TICK_W-1:0]               i_gap_threshold,
    output t_status                              o_status,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_wr_addr
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = PH_IDLE,
        ST_MARK  = PH_MARK,
        ST_SPACE = PH_SPACE,
        ST_STOP  = PH_STOP
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_ovf, n_ovf;

    logic [TICK_W-1:0] w_tick_inc;
    logic              w_store;
    logic [ADDR_W-1:0] w_waddr;

    // saturating tick timer
    assign w_tick_inc = (r_tick == {TICK_W{1'b1}}) ? r_tick : r_tick + 1'b1;

    // next state for one tick or rearm
    always_comb begin
        n_phase = r_phase;
        n_tick  = w_tick_inc;
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        w_store = 1'b0;
        w_waddr = r_fill[ADDR_W-1:0];
        if (i_rearm) begin
            n_phase = ST_IDLE;
            n_fill  = '0;
            n_tick  = r_tick;
        end else if (r_fill >= CNT_W'(BUFFER_DEPTH)) begin
            n_ovf   = 1'b1;
            n_phase = ST_STOP;
        end else begin
            case (r_phase)
                ST_IDLE: begin
                    if (i_is_mark) begin
                        n_tick = '0;
                        if (w_tick_inc >= i_gap_threshold) begin
                            // gap long enough: capture starts with the gap length
                            n_ovf   = 1'b0;
                            w_store = 1'b1;
                            w_waddr = '0;
                            n_fill  = CNT_W'(1);
                            n_phase = ST_MARK;
                        end
                    end
                end
                ST_MARK: begin
                    if (!i_is_mark) begin
                        w_store = 1'b1;
                        n_fill  = r_fill + 1'b1;
                        n_tick  = '0;
                        n_phase = ST_SPACE;
                    end
                end
                ST_SPACE: begin
                    if (i_is_mark) begin
                        w_store = 1'b1;
                        n_fill  = r_fill + 1'b1;
                        n_tick  = '0;
                        n_phase = ST_MARK;
                    end else if (w_tick_inc > i_gap_threshold) begin
                        n_phase = ST_STOP;
                    end
                end
                ST_STOP: begin
                    if (i_is_mark) begin
                        n_tick = '0;
                    end
                end
                default: begin
                    n_phase = ST_IDLE;
                end
            endcase
        end
    end

    // status seen after this tick
    always_comb begin
        o_status              = '0;
        o_status.rx_state     = n_phase;
        o_status.stored_valid = w_store;
        o_status.stored_index = w_store ? 7'(w_waddr) : 7'd0;
        o_status.stored_ticks = w_store ? w_tick_inc : '0;
        o_status.length       = 8'(n_fill);
        o_status.overflowed   = n_ovf;
    end

    assign o_wr_addr = w_waddr;

    // state registers, advance once per committed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_IDLE;
            r_tick  <= '0;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// File: sv/ir_pulse_width_capture_unit.sv
// top level of the ir pulse width capture unit
// Infrared raw pulse receiver. Each slave transaction is one 50 us tick:
// tdata carries the sampled receiver level and a buffer read index, tuser the
// rearm flag. A mark after a long enough gap starts a capture; every mark and
// space length is then written into the raw duration buffer, and a space
// longer than gap_threshold ends the capture. A full buffer sets the overflow
// flag and stops the receiver until a rearm transaction.
// Every slave transaction gives exactly one master transaction carrying the
// phase, the duration stored this tick, the fill length, the overflow flag
// and the buffer entry at the read index.
// Each accepted transaction passes the input register, then the result register;
// one per cycle is sustained while the master is ready. The input register feeds
// the state update and the buffer ram read, the result register holds the read data.
// The config channel (gap_threshold, mark_level) is always ready; the user
// must write it only while the unit is idle, which the unit does not enforce.
// Reset clears the state machine and pipeline valids; buffer contents are
// undefined until written. No clearing pass is run.
// A stalled master side holds the result and back-pressures the slave side
// once both pipeline registers are full.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_width_capture_unit
    import irpwc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // ir_level[0], read_index[7:1]
    input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,  // rearm[0]
    // master stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // rx_state[1:0], stored_valid[2], stored_index[9:3], stored_ticks[25:10],
    // length[33:26], overflowed[34], read_ticks[50:35], zero[55:51]
    output logic      [M_TDATA_W-1:0]  m_axis_tdata,
    // config write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    // configuration registers
    logic [TICK_W-1:0] r_gap_threshold;
    logic              r_mark_level;

    // input stage
    logic              r_s1_valid;
    logic              r_s1_level;
    logic              r_s1_rearm;
    logic [6:0]        r_s1_ridx;

    // result stage
    logic              r_s2_valid;
    t_status           r_s2_status;
    logic              r_s2_bypass;
    logic              r_s2_oor;

    logic              w_in_fire;
    logic              w_s2_free;
    logic              w_s1_adv;
    logic              w_in_range;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_waddr;
    t_status           w_status;
    logic [TICK_W-1:0] w_ram_rdata;
    t_result           w_result;

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_threshold <= 16'd100;
            r_mark_level    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAP_THRESHOLD: r_gap_threshold <= i_cfg_data;
                CFG_MARK_LEVEL:    r_mark_level    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake
    assign w_s2_free     = !r_s2_valid || m_axis_tready;
    assign w_s1_adv      = r_s1_valid && w_s2_free;
    assign s_axis_tready = !r_s1_valid || w_s2_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_level <= s_axis_tdata[0];
            r_s1_ridx  <= s_axis_tdata[7:1];
            r_s1_rearm <= s_axis_tuser[0];
        end
    end

    // capture state machine
    irpwc_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_s1_adv),
        .i_is_mark      (r_s1_level == r_mark_level),
        .i_rearm        (r_s1_rearm),
        .i_gap_threshold(r_gap_threshold),
        .o_status       (w_status),
        .o_wr_addr      (w_waddr)
    );

    // buffer read address and range check
    assign w_in_range = 32'(r_s1_ridx) < BUFFER_DEPTH;
    assign w_raddr    = ADDR_W'(r_s1_ridx);

    // raw duration buffer
    irpwc_ram #(
        .WIDTH(TICK_W),
        .DEPTH(BUFFER_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_s1_adv && w_status.stored_valid),
        .i_waddr(w_waddr),
        .i_wdata(w_status.stored_ticks),
        .i_re   (w_s1_adv),
        .i_raddr(w_raddr),
        .o_rdata(w_ram_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_status <= w_status;
            r_s2_oor    <= !w_in_range;
            // a read of the entry written by the same tick takes the new value
            r_s2_bypass <= w_status.stored_valid && (w_waddr == w_raddr);
        end
    end

    // output assembly
    always_comb begin
        w_result.status = r_s2_status;
        if (r_s2_oor) begin
            w_result.read_ticks = '0;
        end else if (r_s2_bypass) begin
            w_result.read_ticks = r_s2_status.stored_ticks;
        end else begin
            w_result.read_ticks = w_ram_rdata;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, w_result};

endmodule

`default_nettype wire

// File: sv/irpwc_checker.sv
// port level checks for the ir pulse width capture unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module irpwc_checker
    import irpwc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_result w_res;

    assign w_res = t_result'(m_axis_tdata[RESULT_W-1:0]);

    // no result is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its data
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a stored duration means an active capture, never an overflowed one
    a_store_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.status.stored_valid |-> !w_res.status.overflowed)
        else $error("duration stored while overflowed");

    // the first buffer entry is only written when a capture starts on a mark
    a_first_is_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.status.stored_valid && (w_res.status.stored_index == 7'd0)
        |-> w_res.status.rx_state == PH_MARK && w_res.status.length == 8'd1)
        else $error("first entry stored outside capture start");

    // overflow only ever shows while stopped or after rearm
    a_ovf_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.status.overflowed
        |-> w_res.status.rx_state == PH_STOP || w_res.status.rx_state == PH_IDLE)
        else $error("overflow flag in an active phase");

endmodule

bind ir_pulse_width_capture_unit irpwc_checker u_irpwc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
